// ===== src/sdu_pkg.sv =====
// Shared types and constants for the signed divider unit.
// No dependencies.
package sdu_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 9;
  localparam int unsigned QuoW       = 2 * DataW;
  localparam int unsigned QueueDepth = 2;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Register offsets, primary and read mirrors
  localparam logic [AddrW-1:0] AddrDvsr        = 9'h100;
  localparam logic [AddrW-1:0] AddrDvdnt32     = 9'h104;
  localparam logic [AddrW-1:0] AddrCtrl        = 9'h108;
  localparam logic [AddrW-1:0] AddrVect        = 9'h10C;
  localparam logic [AddrW-1:0] AddrDvdntH      = 9'h110;
  localparam logic [AddrW-1:0] AddrDvdntL      = 9'h114;
  localparam logic [AddrW-1:0] AddrDvdntH2     = 9'h118;
  localparam logic [AddrW-1:0] AddrDvdntL2     = 9'h11C;
  localparam logic [AddrW-1:0] AddrDvsrMir     = 9'h120;
  localparam logic [AddrW-1:0] AddrDvdnt32Mir  = 9'h124;
  localparam logic [AddrW-1:0] AddrCtrlMir     = 9'h128;
  localparam logic [AddrW-1:0] AddrVectMir     = 9'h12C;
  localparam logic [AddrW-1:0] AddrDvdntHMir   = 9'h130;
  localparam logic [AddrW-1:0] AddrDvdntLMir   = 9'h134;
  localparam logic [AddrW-1:0] AddrDvdntH2Mir  = 9'h138;
  localparam logic [AddrW-1:0] AddrDvdntL2Mir  = 9'h13C;

  localparam int unsigned CtrlW = 2;
  localparam int unsigned VectW = 16;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_RD_DVSR,
    CMD_RD_LOW,
    CMD_RD_HIGH,
    CMD_RD_CTRL,
    CMD_RD_VECT,
    CMD_WR_DVSR,
    CMD_WR_CTRL,
    CMD_WR_VECT,
    CMD_WR_HIGH,
    CMD_DIV32,
    CMD_DIV64
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

// ===== src/signed_divider_unit.sv =====
// Top level of the signed divider unit: front decode queue plus back execution.
// Depends on sdu_pkg, sdu_front, sdu_back.
//
//   channel  | signals                          | handshake
//   ---------+----------------------------------+---------------------------------
//   access   | op_i, addr_i, data_i             | taken when start && !busy
//   result   | read_data_o, div_irq_o           | done_o, valid one cycle, no stall
//
// Reads and plain register writes give their result in the cycle after the back end
// takes the item from the queue. A divide start with a nonzero divisor goes to
// the divider loop, which produces one of 64 quotient bits per cycle; the back end
// then sets done_o with the signed result. busy rises while the queue is full.
// Reset is asynchronous, active low; all control state and queue clear at once.
module signed_divider_unit #(
  parameter int unsigned QUEUE_DEPTH = sdu_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op_i,
  input  logic [sdu_pkg::AddrW-1:0] addr_i,
  input  logic [sdu_pkg::DataW-1:0] data_i,
  output logic                      done_o,
  output logic [sdu_pkg::DataW-1:0] read_data_o,
  output logic                      div_irq_o
);
  import sdu_pkg::*;

  cmd_t head;
  logic empty, pop;

  sdu_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .op_i    (op_i),
    .addr_i  (addr_i),
    .data_i  (data_i),
    .full_o  (busy),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  sdu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .div_irq_o   (div_irq_o)
  );

endmodule

// ===== src/sdu_front.sv =====
// Front end: decodes bus accesses into commands and queues them.
// Depends on sdu_pkg.
module sdu_front #(
  parameter int unsigned QUEUE_DEPTH = sdu_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       op_i,
  input  logic [sdu_pkg::AddrW-1:0]  addr_i,
  input  logic [sdu_pkg::DataW-1:0]  data_i,
  output logic                       full_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output sdu_pkg::cmd_t              head_o
);
  import sdu_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            cmd;
  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    cmd.data = data_i;
    cmd.kind = CMD_NOP;
    if (op_i == OpWrite) begin
      unique case (addr_i)
        AddrDvsr:    cmd.kind = CMD_WR_DVSR;
        AddrDvdnt32: cmd.kind = CMD_DIV32;
        AddrCtrl:    cmd.kind = CMD_WR_CTRL;
        AddrVect:    cmd.kind = CMD_WR_VECT;
        AddrDvdntH:  cmd.kind = CMD_WR_HIGH;
        AddrDvdntL:  cmd.kind = CMD_DIV64;
        default:     cmd.kind = CMD_NOP;
      endcase
    end else begin
      unique case (addr_i) inside
        AddrDvsr, AddrDvsrMir: cmd.kind = CMD_RD_DVSR;
        AddrDvdnt32, AddrDvdntL, AddrDvdntL2, AddrDvdnt32Mir,
        AddrDvdntLMir, AddrDvdntL2Mir: cmd.kind = CMD_RD_LOW;
        AddrCtrl, AddrCtrlMir: cmd.kind = CMD_RD_CTRL;
        AddrVect, AddrVectMir: cmd.kind = CMD_RD_VECT;
        AddrDvdntH, AddrDvdntH2, AddrDvdntHMir,
        AddrDvdntH2Mir: cmd.kind = CMD_RD_HIGH;
        default: cmd.kind = CMD_NOP;
      endcase
    end
  end

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// ===== src/sdu_divider.sv =====
// Unsigned 64/32 restoring divider, one quotient bit per cycle.
// Depends on sdu_pkg.
module sdu_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sdu_pkg::QuoW-1:0]  num_i,
  input  logic [sdu_pkg::DataW-1:0] den_i,
  output logic                      done_o,
  output logic [sdu_pkg::QuoW-1:0]  quo_o,
  output logic [sdu_pkg::DataW-1:0] rem_o
);
  import sdu_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [QuoW-1:0]  num_q, num_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW:0]   shifted;
  logic [DataW+1:0] diff;
  logic             fits;

  // partial remainder stays below the divisor, which is at most 2^31
  assign shifted = {rem_q, num_q[QuoW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !diff[DataW+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = fits ? diff[DataW-1:0] : shifted[DataW-1:0];
      num_d = {num_q[QuoW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(QuoW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/sdu_back.sv =====
// Back end: register file, command execution and sign handling around the divider.
// Depends on sdu_pkg and sdu_divider.
module sdu_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  sdu_pkg::cmd_t             head_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic [sdu_pkg::DataW-1:0] read_data_o,
  output logic                      div_irq_o
);
  import sdu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [DataW-1:0] dvsr_q, dvsr_d;
  logic [DataW-1:0] high_q, high_d;
  logic [DataW-1:0] low_q, low_d;
  logic [CtrlW-1:0] ctrl_q, ctrl_d;
  logic [VectW-1:0] vect_q, vect_d;
  logic             nneg_q, nneg_d;
  logic             qneg_q, qneg_d;
  logic             done_q, done_d;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic             irq_q;

  logic [QuoW-1:0]  num_sel, nmag;
  logic [DataW-1:0] dmag;
  logic             nneg, dneg, dvsr_zero;
  logic             div_start, div_done;
  logic [QuoW-1:0]  quo;
  logic [DataW-1:0] rem;
  logic             ovf;

  assign num_sel   = (head_i.kind == CMD_DIV32) ?
                     {{DataW{head_i.data[DataW-1]}}, head_i.data} : {high_q, head_i.data};
  assign nneg      = num_sel[QuoW-1];
  assign nmag      = nneg ? (~num_sel + QuoW'(1)) : num_sel;
  assign dneg      = dvsr_q[DataW-1];
  assign dmag      = dneg ? (~dvsr_q + DataW'(1)) : dvsr_q;
  assign dvsr_zero = (dvsr_q == '0);

  sdu_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (nmag),
    .den_i   (dmag),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  // quotient must fit signed 32 bits; a negative one may reach -2^31
  assign ovf = (|quo[QuoW-1:DataW]) ||
               (qneg_q ? (quo[DataW-1] && (|quo[DataW-2:0])) : quo[DataW-1]);

  always_comb begin
    state_d   = state_q;
    dvsr_d    = dvsr_q;
    high_d    = high_q;
    low_d     = low_q;
    ctrl_d    = ctrl_q;
    vect_d    = vect_q;
    nneg_d    = nneg_q;
    qneg_d    = qneg_q;
    done_d    = 1'b0;
    rdata_d   = '0;
    pop_o     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          done_d = 1'b1;
          case (head_i.kind)
            CMD_RD_DVSR: rdata_d = dvsr_q;
            CMD_RD_LOW:  rdata_d = low_q;
            CMD_RD_HIGH: rdata_d = high_q;
            CMD_RD_CTRL: rdata_d = DataW'(ctrl_q);
            CMD_RD_VECT: rdata_d = DataW'(vect_q);
            CMD_WR_DVSR: dvsr_d  = head_i.data;
            CMD_WR_CTRL: ctrl_d  = head_i.data[CtrlW-1:0];
            CMD_WR_VECT: vect_d  = head_i.data[VectW-1:0];
            CMD_WR_HIGH: high_d  = head_i.data;
            CMD_DIV32, CMD_DIV64: begin
              if (dvsr_zero) begin
                low_d     = head_i.data;
                ctrl_d[0] = 1'b1;
                if (head_i.kind == CMD_DIV32) begin
                  high_d = {DataW{head_i.data[DataW-1]}};
                end
              end else begin
                done_d    = 1'b0;
                div_start = 1'b1;
                nneg_d    = nneg;
                qneg_d    = nneg ^ dneg;
                state_d   = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          low_d     = qneg_q ? (~quo[DataW-1:0] + DataW'(1)) : quo[DataW-1:0];
          high_d    = nneg_q ? (~rem + DataW'(1)) : rem;
          ctrl_d[0] = ovf;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      high_q  <= '0;
      low_q   <= '0;
      ctrl_q  <= '0;
      vect_q  <= '0;
      done_q  <= 1'b0;
      rdata_q <= '0;
      irq_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      high_q  <= high_d;
      low_q   <= low_d;
      ctrl_q  <= ctrl_d;
      vect_q  <= vect_d;
      done_q  <= done_d;
      rdata_q <= rdata_d;
      irq_q   <= ctrl_d[0] & ctrl_d[1];
    end
  end

  // divisor has no reset value; sign flags only matter while dividing
  always_ff @(posedge clk_i) begin
    dvsr_q <= dvsr_d;
    nneg_q <= nneg_d;
    qneg_q <= qneg_d;
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign div_irq_o   = irq_q;

endmodule

// ===== src/sdu_checker.sv =====
// Port-level checks for the signed divider unit, bound to the top level.
// Depends on sdu_pkg and signed_divider_unit.
module sdu_checker #(
  parameter int unsigned QUEUE_DEPTH = sdu_pkg::QueueDepth
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [sdu_pkg::DataW-1:0] read_data_o
);

  // items taken but not yet answered
  logic [7:0] pend_q, pend_d;
  logic       acc;

  assign acc = start && !busy;

  always_comb begin
    pend_d = pend_q;
    if (acc && !done_o) begin
      pend_d = pend_q + 8'd1;
    end else if (done_o && !acc) begin
      pend_d = pend_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pend_q != 8'd0))
    else $error("result strobe without a pending item");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 8'd0) |-> !busy)
    else $error("busy with no pending item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(acc))
    else $error("busy rose without an accepted item");

  a_quiet_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (read_data_o == '0))
    else $error("read data driven outside a result strobe");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'(QUEUE_DEPTH + 2))
    else $error("more items pending than the unit can hold");

endmodule

bind signed_divider_unit sdu_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sdu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .read_data_o (read_data_o)
);

// ===== test/signed_divider_unit_test.sv =====
// Self-checking testbench for signed_divider_unit: bus reads and writes, 32/32 and 64/32 divides.
// Every access is predicted in the testbench itself and compared with the result strobe.
// Depends on sdu_pkg and the signed_divider_unit RTL.
module signed_divider_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdu_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned PhaseItems = 575;
  localparam logic [DataW-1:0] CtrlIrqEnable = 32'h2;

  // every long-aligned offset the divider decodes
  localparam logic [AddrW-1:0] RegMap [16] = '{
    AddrDvsr, AddrDvdnt32, AddrCtrl, AddrVect, AddrDvdntH, AddrDvdntL,
    AddrDvdntH2, AddrDvdntL2, AddrDvsrMir, AddrDvdnt32Mir, AddrCtrlMir,
    AddrVectMir, AddrDvdntHMir, AddrDvdntLMir, AddrDvdntH2Mir, AddrDvdntL2Mir
  };

  typedef struct {
    logic [DataW-1:0] rdata;
    logic             irq;
  } access_result_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start  = 1'b0;
  logic             busy;
  logic             op_i   = OpRead;
  logic [AddrW-1:0] addr_i = '0;
  logic [DataW-1:0] data_i = '0;
  logic             done_o;
  logic [DataW-1:0] read_data_o;
  logic             div_irq_o;

  // register file as the bus sees it
  logic [DataW-1:0] shadow_divisor = '0;
  logic [DataW-1:0] shadow_high    = '0;
  logic [DataW-1:0] shadow_low     = '0;
  logic [CtrlW-1:0] shadow_ctrl    = '0;
  logic [VectW-1:0] shadow_vect    = '0;

  access_result_t pending_results[$];

  int unsigned idle_pct       = 0;
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned n_reads        = 0;
  int unsigned n_div32        = 0;
  int unsigned n_div64        = 0;
  int unsigned n_by_zero      = 0;
  int unsigned n_overflow     = 0;

  signed_divider_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .div_irq_o   (div_irq_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endfunction

  // Signed divide on magnitudes; quotient truncates toward zero,
  // remainder follows the dividend's sign.
  function automatic void apply_divide(logic [2*DataW-1:0] num);
    logic             num_neg, dvs_neg, quo_neg, ovf;
    logic [DataW-1:0] dvs_abs;
    logic [2*DataW-1:0] num_mag, dvs_mag, quo_mag, rem_mag, quo, rem;
    num_neg = num[2*DataW-1];
    dvs_neg = shadow_divisor[DataW-1];
    quo_neg = num_neg != dvs_neg;
    num_mag = num_neg ? -num : num;
    dvs_abs = dvs_neg ? -shadow_divisor : shadow_divisor;
    dvs_mag = {{DataW{1'b0}}, dvs_abs};
    quo_mag = num_mag / dvs_mag;
    rem_mag = num_mag % dvs_mag;
    ovf = quo_neg ? (quo_mag > 64'h8000_0000) : (quo_mag > 64'h7FFF_FFFF);
    quo = quo_neg ? -quo_mag : quo_mag;
    rem = num_neg ? -rem_mag : rem_mag;
    shadow_low  = quo[DataW-1:0];
    shadow_high = rem[DataW-1:0];
    if (ovf) begin
      shadow_ctrl[0] = 1'b1;
      n_overflow++;
    end else begin
      shadow_ctrl[0] = 1'b0;
    end
  endfunction

  function automatic access_result_t predict_access(logic op, logic [AddrW-1:0] addr,
                                                    logic [DataW-1:0] data);
    access_result_t res;
    res.rdata = '0;
    if (op == OpWrite) begin
      case (addr)
        AddrDvsr: shadow_divisor = data;
        AddrDvdnt32: begin
          n_div32++;
          if (shadow_divisor == '0) begin
            n_by_zero++;
            shadow_low     = data;
            shadow_high    = {DataW{data[DataW-1]}};
            shadow_ctrl[0] = 1'b1;
          end else begin
            apply_divide({{DataW{data[DataW-1]}}, data});
          end
        end
        AddrCtrl:   shadow_ctrl = data[CtrlW-1:0];
        AddrVect:   shadow_vect = data[VectW-1:0];
        AddrDvdntH: shadow_high = data;
        AddrDvdntL: begin
          n_div64++;
          if (shadow_divisor == '0) begin
            n_by_zero++;
            shadow_low     = data;
            shadow_ctrl[0] = 1'b1;
          end else begin
            apply_divide({shadow_high, data});
          end
        end
        default: ;
      endcase
    end else begin
      n_reads++;
      case (addr)
        AddrDvsr, AddrDvsrMir: res.rdata = shadow_divisor;
        AddrDvdnt32, AddrDvdntL, AddrDvdntL2, AddrDvdnt32Mir, AddrDvdntLMir,
        AddrDvdntL2Mir: res.rdata = shadow_low;
        AddrCtrl, AddrCtrlMir: res.rdata = DataW'(shadow_ctrl);
        AddrVect, AddrVectMir: res.rdata = DataW'(shadow_vect);
        AddrDvdntH, AddrDvdntH2, AddrDvdntHMir, AddrDvdntH2Mir: res.rdata = shadow_high;
        default: res.rdata = '0;
      endcase
    end
    res.irq = shadow_ctrl[0] & shadow_ctrl[1];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    g = 0;
    if (idle_pct == 0) return 0;
    // now and then a long pause so gaps land anywhere in a divide
    if ($urandom_range(99) < 5) return $urandom_range(90, 1);
    while (g < 40 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(255));
      6: return -32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [AddrW-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return RegMap[$urandom_range(15)];
    if (r < 85) return AddrW'($urandom);
    return AddrDvsr + AddrW'($urandom_range(63));
  endfunction

  // Start stays high when the next item follows at once; callers that pause
  // must go through wait_for_results, which lowers it.
  task automatic send_access(input logic op, input logic [AddrW-1:0] addr,
                             input logic [DataW-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    op_i   <= op;
    addr_i <= addr;
    data_i <= data;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_access(op, addr, data));
    items_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_reset_state();
    send_access(OpRead, AddrDvdntL, $urandom);
    send_access(OpRead, AddrDvdntH, $urandom);
    send_access(OpRead, AddrCtrl, $urandom);
    send_access(OpRead, AddrVect, $urandom);
    wait_for_results();
  endtask

  task automatic test_register_map();
    send_access(OpWrite, AddrDvsr, 32'd7);
    send_access(OpWrite, AddrVect, 32'hFFFF_FFFF);
    send_access(OpRead, AddrVectMir, 32'hFFFF_FFFF);
    send_access(OpWrite, AddrCtrl, 32'hFFFF_FFFF);
    send_access(OpWrite, AddrCtrl, CtrlIrqEnable);
    send_access(OpWrite, AddrDvsr + AddrW'(1), 32'h5A5A_5A5A);
    send_access(OpRead, '1, '0);
    send_access(OpRead, '0, '1);
    wait_for_results();
  endtask

  task automatic test_divide_corners();
    send_access(OpWrite, AddrDvdnt32, 32'hFFFF_FF9C);
    send_access(OpRead, AddrDvdntH, '0);
    // most negative over -1 wraps and flags
    send_access(OpWrite, AddrDvsr, 32'hFFFF_FFFF);
    send_access(OpWrite, AddrDvdnt32, 32'h8000_0000);
    send_access(OpRead, AddrDvdnt32Mir, '0);
    send_access(OpWrite, AddrDvdntH, 32'h7FFF_FFFF);
    send_access(OpWrite, AddrDvdntL, 32'hFFFF_FFFF);
    // positive quotient of exactly 2^31 does not fit
    send_access(OpWrite, AddrDvsr, 32'h8000_0000);
    send_access(OpWrite, AddrDvdntH, 32'hC000_0000);
    send_access(OpWrite, AddrDvdntL, 32'h0000_0000);
    send_access(OpRead, AddrDvdntLMir, '0);
    // zero divisor: 32-bit start sign-extends, 64-bit start keeps the high word
    send_access(OpWrite, AddrDvsr, 32'h0000_0000);
    send_access(OpWrite, AddrDvdnt32, 32'h8000_0001);
    send_access(OpRead, AddrDvdntH2, '0);
    send_access(OpWrite, AddrDvdntL, 32'h1234_5678);
    send_access(OpRead, AddrCtrlMir, '0);
    send_access(OpWrite, AddrDvsr, 32'd3);
    send_access(OpWrite, AddrDvdntH, 32'h8000_0000);
    send_access(OpWrite, AddrDvdntL, 32'h0000_0000);
    wait_for_results();
  endtask

  task automatic send_divide_sequence();
    logic [DataW-1:0] lo, hi;
    if ($urandom_range(2) == 0) send_access(OpWrite, AddrDvsr, pick_word());
    if ($urandom_range(1) == 1) begin
      lo = pick_word();
      case ($urandom_range(2))
        0: hi = {DataW{lo[DataW-1]}};
        1: hi = $urandom_range(1) ? 32'($urandom_range(3)) : ~32'($urandom_range(3));
        default: hi = pick_word();
      endcase
      if ($urandom_range(4) != 0) send_access(OpWrite, AddrDvdntH, hi);
      send_access(OpWrite, AddrDvdntL, lo);
    end else begin
      send_access(OpWrite, AddrDvdnt32, pick_word());
    end
    repeat ($urandom_range(2, 1)) send_access(OpRead, RegMap[$urandom_range(15)], $urandom);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned pct);
    int unsigned target;
    target   = items_sent + n_items;
    idle_pct = pct;
    while (items_sent < target) begin
      if ($urandom_range(99) < 45) begin
        send_divide_sequence();
      end else begin
        send_access($urandom_range(1) ? OpWrite : OpRead, pick_addr(), pick_word());
      end
    end
    wait_for_results();
  endtask

  always @(posedge clk_i) begin : result_check
    access_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: read_data %h irq %b",
                                read_data_o, div_irq_o));
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.rdata) begin
          flag_mismatch($sformatf("read_data expected %h got %h", want.rdata, read_data_o));
        end
        if (div_irq_o !== want.irq) begin
          flag_mismatch($sformatf("div_irq expected %b got %b", want.irq, div_irq_o));
        end
      end
    end
  end

  // stall detector: no item taken and no result for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("[signed_divider_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_register_map();
    test_divide_corners();
    test_random_traffic(PhaseItems, 0);
    test_random_traffic(PhaseItems, 72);
    test_random_traffic(PhaseItems, 18);

    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("run: %0d accesses, %0d reads, %0d 32/32 and %0d 64/32 divides",
             items_sent, n_reads, n_div32, n_div64);
    $display("run: %0d zero-divisor starts, %0d quotient overflows, %0d mismatches",
             n_by_zero, n_overflow, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[signed_divider_unit] OK");
    end else begin
      $display("[signed_divider_unit] ERROR");
    end
    $finish;
  end

endmodule
